// ===== design/assert_macros.svh =====
// Assertion macros used by the scaler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/rbfs_pkg.sv =====
// Shared types and constants of the RGBA bilinear fit scaler.
package rbfs_pkg;
   localparam int SRC_W     = 9;
   localparam int FIT_W     = 13;
   localparam int DEST_W    = 12;
   localparam int ADDR_W    = 16;
   localparam int CH_W      = 8;
   localparam int PIX_W     = 4 * CH_W;
   localparam int CSR_IDX_W = 8;
   localparam int M_W       = DEST_W + 1 + SRC_W;

   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_WIDTH  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_HEIGHT = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_WIDTH   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_HEIGHT  = 8'd3;

   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      FIT_IDLE,
      FIT_MUL,
      FIT_SETUP,
      FIT_DIV
   } fit_state_type;

   typedef struct packed {
      logic             busy;
      logic [SRC_W-1:0] src_w;
      logic [SRC_W-1:0] src_h;
      logic [FIT_W-1:0] fit_w;
      logic [FIT_W-1:0] fit_h;
   } fit_status_type;

   typedef struct packed {
      logic              sample;
      logic              oob;
      logic [ADDR_W-1:0] load_index;
      logic [PIX_W-1:0]  pixel;
   } side_type;
endpackage

// ===== design/rbfs_fit_unit.sv =====
// Configuration registers and the sequential aspect-fit computation.
module rbfs_fit_unit #(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int MAX_OUT_DIM    = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rbfs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rbfs_pkg::FIT_W-1:0]           csr_data,
   output rbfs_pkg::fit_status_type             status
);
   localparam int SW = rbfs_pkg::SRC_W;
   localparam int FW = rbfs_pkg::FIT_W;
   localparam int PW = SW + FW;
   localparam int DVW = PW + 2;
   localparam int SRC_TOP = (1 << SW) - 1;
   localparam int OUT_TOP = (1 << FW) - 1;
   localparam int SWM_I = (MAX_SRC_WIDTH > SRC_TOP) ? SRC_TOP : MAX_SRC_WIDTH;
   localparam int SHM_I = (MAX_SRC_HEIGHT > SRC_TOP) ? SRC_TOP : MAX_SRC_HEIGHT;
   localparam int OM_I  = (MAX_OUT_DIM > OUT_TOP) ? OUT_TOP : MAX_OUT_DIM;
   localparam logic [SW-1:0] SW_MAX = SWM_I[SW-1:0];
   localparam logic [SW-1:0] SH_MAX = SHM_I[SW-1:0];
   localparam logic [FW-1:0] O_MAX  = OM_I[FW-1:0];
   localparam int CNT_W = $clog2(FW + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FW - 1);

   rbfs_pkg::fit_state_type state_ff, state_in;

   logic [SW-1:0]    src_w_raw_ff, src_h_raw_ff;
   logic [FW-1:0]    lim_w_raw_ff, lim_h_raw_ff;
   logic [SW-1:0]    cw_ff, ch_ff;
   logic [FW-1:0]    clw_ff, clh_ff;
   logic [PW-1:0]    pw_ff, ph_ff;
   logic             sel_w_ff;
   logic [SW:0]      div_ff;
   logic [SW:0]      rem_ff;
   logic [FW-1:0]    lo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [FW-1:0]    fit_w_ff, fit_h_ff;

   logic [SW-1:0]  cw_c, ch_c;
   logic [FW-1:0]  clw_c, clh_c;
   logic           known_idx;
   logic           fits_w;
   logic [DVW-1:0] dividend;
   logic [SW:0]    divisor;
   logic [SW+1:0]  trial;
   logic           take;
   logic [SW:0]    rem_next;
   logic [FW-1:0]  quot;
   logic [FW-1:0]  quot_min;

   always_comb begin
      cw_c  = (src_w_raw_ff == '0) ? SW'(1) : (src_w_raw_ff > SW_MAX) ? SW_MAX : src_w_raw_ff;
      ch_c  = (src_h_raw_ff == '0) ? SW'(1) : (src_h_raw_ff > SH_MAX) ? SH_MAX : src_h_raw_ff;
      clw_c = (lim_w_raw_ff == '0) ? FW'(1) : (lim_w_raw_ff > O_MAX) ? O_MAX : lim_w_raw_ff;
      clh_c = (lim_h_raw_ff == '0) ? FW'(1) : (lim_h_raw_ff > O_MAX) ? O_MAX : lim_h_raw_ff;
   end

   // The limited side keeps its limit; the other side is rounded to nearest.
   always_comb begin
      fits_w = (pw_ff <= ph_ff);
      if (fits_w) begin
         dividend = DVW'({pw_ff, 1'b0}) + DVW'(cw_ff);
         divisor  = {cw_ff, 1'b0};
      end else begin
         dividend = DVW'({ph_ff, 1'b0}) + DVW'(ch_ff);
         divisor  = {ch_ff, 1'b0};
      end
   end

   always_comb begin
      trial    = {rem_ff, lo_ff[FW-1]};
      take     = (trial >= {1'b0, div_ff});
      rem_next = take ? (SW+1)'(trial - {1'b0, div_ff}) : trial[SW:0];
      quot     = {lo_ff[FW-2:0], take};
      quot_min = (quot == '0) ? FW'(1) : quot;
   end

   always_comb begin
      case (csr_index) inside
         rbfs_pkg::REG_SOURCE_WIDTH, rbfs_pkg::REG_SOURCE_HEIGHT,
         rbfs_pkg::REG_LIMIT_WIDTH, rbfs_pkg::REG_LIMIT_HEIGHT: known_idx = 1'b1;
         default: known_idx = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbfs_pkg::FIT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      csr_ready = 1'b0;
      case (state_ff)
         rbfs_pkg::FIT_IDLE: begin
            csr_ready = 1'b1;
            if (csr_valid && known_idx) begin
               state_in = rbfs_pkg::FIT_MUL;
            end
         end
         rbfs_pkg::FIT_MUL:   state_in = rbfs_pkg::FIT_SETUP;
         rbfs_pkg::FIT_SETUP: state_in = rbfs_pkg::FIT_DIV;
         rbfs_pkg::FIT_DIV: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = rbfs_pkg::FIT_IDLE;
            end
         end
         default: state_in = rbfs_pkg::FIT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_raw_ff <= SW'(1);
         src_h_raw_ff <= SW'(1);
         lim_w_raw_ff <= FW'(1);
         lim_h_raw_ff <= FW'(1);
         cw_ff        <= SW'(1);
         ch_ff        <= SW'(1);
         fit_w_ff     <= FW'(1);
         fit_h_ff     <= FW'(1);
      end else begin
         if (state_ff == rbfs_pkg::FIT_IDLE && csr_valid) begin
            case (csr_index)
               rbfs_pkg::REG_SOURCE_WIDTH:  src_w_raw_ff <= csr_data[SW-1:0];
               rbfs_pkg::REG_SOURCE_HEIGHT: src_h_raw_ff <= csr_data[SW-1:0];
               rbfs_pkg::REG_LIMIT_WIDTH:   lim_w_raw_ff <= csr_data;
               rbfs_pkg::REG_LIMIT_HEIGHT:  lim_h_raw_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == rbfs_pkg::FIT_MUL) begin
            cw_ff <= cw_c;
            ch_ff <= ch_c;
         end
         if (state_ff == rbfs_pkg::FIT_DIV && cnt_ff == CNT_LAST) begin
            if (sel_w_ff) begin
               fit_w_ff <= clw_ff;
               fit_h_ff <= quot_min;
            end else begin
               fit_w_ff <= quot_min;
               fit_h_ff <= clh_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         rbfs_pkg::FIT_MUL: begin
            clw_ff <= clw_c;
            clh_ff <= clh_c;
            pw_ff  <= PW'(clw_c) * PW'(ch_c);
            ph_ff  <= PW'(clh_c) * PW'(cw_c);
         end
         rbfs_pkg::FIT_SETUP: begin
            sel_w_ff <= fits_w;
            div_ff   <= divisor;
            rem_ff   <= dividend[FW+SW:FW];
            lo_ff    <= dividend[FW-1:0];
            cnt_ff   <= '0;
         end
         rbfs_pkg::FIT_DIV: begin
            rem_ff <= rem_next;
            lo_ff  <= quot;
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         default: ;
      endcase
   end

   assign status.busy  = (state_ff != rbfs_pkg::FIT_IDLE);
   assign status.src_w = cw_ff;
   assign status.src_h = ch_ff;
   assign status.fit_w = fit_w_ff;
   assign status.fit_h = fit_h_ff;
endmodule

// ===== design/rbfs_pos_div.sv =====
// Pipelined restoring divider that turns one output index into a source position.
module rbfs_pos_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      en,
   input  logic [rbfs_pkg::FIT_W-1:0]                fit,
   input  logic [rbfs_pkg::M_W-1:0]                  m_in,
   output logic [FRAC_BITS+rbfs_pkg::SRC_W-1:0]      q_out
);
   localparam int SW = rbfs_pkg::SRC_W;
   localparam int FW = rbfs_pkg::FIT_W;
   localparam int MW = rbfs_pkg::M_W;
   localparam int QW = FRAC_BITS + SW;
   localparam int RW = FW + 1;

   logic [RW-1:0] rem_ff [0:QW];
   logic [QW-1:0] q_ff   [0:QW];
   logic [MW-1:0] m_ff   [0:QW-1];
   logic [RW:0]   dsor;

   // Divisor is twice the fitted side; the quotient is the position times 2^FRAC_BITS.
   assign dsor = {1'b0, fit, 1'b0};

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {1'b0, m_in[MW-1:SW]};
         q_ff[0]   <= '0;
         m_ff[0]   <= m_in;
      end
   end

   for (genvar s = 0; s < QW; s++) begin : g_step
      localparam int K = QW - 1 - s;
      logic          nbit;
      logic [RW:0]   trial;
      logic          take;

      if (K >= FRAC_BITS) begin : g_mbit
         assign nbit = m_ff[s][K-FRAC_BITS];
      end else begin : g_zbit
         assign nbit = 1'b0;
      end

      assign trial = {rem_ff[s], nbit};
      assign take  = (trial >= dsor);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1] <= take ? RW'(trial - dsor) : trial[RW-1:0];
            q_ff[s+1]   <= {q_ff[s][QW-2:0], take};
         end
      end

      if (s + 1 < QW) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               m_ff[s+1] <= m_ff[s];
            end
         end
      end
   end

   assign q_out = q_ff[QW];
endmodule

// ===== design/rbfs_pixel_ram.sv =====
// Source pixel memory with one write port and two registered read ports.
module rbfs_pixel_ram (
   input  logic                          clock,
   input  logic                          en,
   input  logic                          we,
   input  logic [rbfs_pkg::ADDR_W-1:0]   waddr,
   input  logic [rbfs_pkg::PIX_W-1:0]    wdata,
   input  logic [rbfs_pkg::ADDR_W-1:0]   raddr0,
   input  logic [rbfs_pkg::ADDR_W-1:0]   raddr1,
   output logic [rbfs_pkg::PIX_W-1:0]    rdata0,
   output logic [rbfs_pkg::PIX_W-1:0]    rdata1
);
   logic [rbfs_pkg::PIX_W-1:0] mem [0:(1 << rbfs_pkg::ADDR_W)-1];

   always_ff @(posedge clock) begin
      if (en && we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rdata0 <= mem[raddr0];
         rdata1 <= mem[raddr1];
      end
   end
endmodule

// ===== design/rgba_bilinear_fit_scaler.sv =====
// Top level of the RGBA bilinear fit scaler.
// The scaler holds an RGBA source raster of up to 65536 pixels and fits it, aspect ratio
// kept, into the limit frame set through the csr port. A load item (tuser 0) writes one
// source pixel; a sample item (tuser 1) returns one item with the bilinear value of one
// output pixel, half-pixel centers, positions clamped to the raster and carried with
// FRAC_BITS fraction bits. Loads return nothing. A coordinate outside the fitted frame
// returns status 1 with zero channels. The pipeline takes one item every cycle while
// no result waits untaken and no refit runs, and computes each sample's source position in
// two position dividers that retire one quotient bit per stage. The pixel store exists in
// two copies, each read at two addresses per cycle, so all four neighbors of a sample come
// out of the memories in the same cycle; loads write both copies in the same stage where
// samples read, so items act on the store strictly in order. Each csr write to one of the
// four registers starts a refit (a multiply state, a setup state and a 13-step divider);
// while it runs, req_tready and csr_ready are low. Configuration is expected only with no
// item in flight.
`include "assert_macros.svh"
module rgba_bilinear_fit_scaler #(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int MAX_OUT_DIM    = 4096,
   parameter int FRAC_BITS      = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // load_index[15:0], in_red[23:16], in_green[31:24], in_blue[39:32],
   // in_alpha[47:40], dest_x[59:48], dest_y[71:60]
   input  logic [71:0]                          req_tdata,
   // action[0]
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24],
   // fitted_width[44:32], fitted_height[57:45], zero fill[63:58]
   output logic [63:0]                          rsp_tdata,
   // status[0]
   output logic                                 rsp_tuser,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rbfs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rbfs_pkg::FIT_W-1:0]           csr_data
);
   localparam int SW   = rbfs_pkg::SRC_W;
   localparam int FW   = rbfs_pkg::FIT_W;
   localparam int DW   = rbfs_pkg::DEST_W;
   localparam int AW   = rbfs_pkg::ADDR_W;
   localparam int CW   = rbfs_pkg::CH_W;
   localparam int MW   = rbfs_pkg::M_W;
   localparam int QW   = FRAC_BITS + SW;
   localparam int ROWW = 2 * SW;
   localparam int WTW  = FRAC_BITS + 1;
   localparam int TOPW = CW + WTW;
   localparam int PRDW = TOPW + WTW;
   localparam logic [WTW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [CW-1:0]  CH_MAX = {CW{1'b1}};

   rbfs_pkg::fit_status_type fit_stat;

   // One enable moves the whole pipeline; it stops only when a result waits untaken.
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en && !fit_stat.busy;

   rbfs_fit_unit #(
      .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
      .MAX_OUT_DIM   (MAX_OUT_DIM)
   ) u_fit (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .status   (fit_stat)
   );

   // Input stage.
   logic          s0_valid_ff;
   logic          s0_action_ff;
   logic [AW-1:0] s0_index_ff;
   logic [31:0]   s0_pixel_ff;
   logic [DW-1:0] s0_dx_ff, s0_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_tvalid && req_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_action_ff <= req_tuser;
         s0_index_ff  <= req_tdata[15:0];
         s0_pixel_ff  <= req_tdata[47:16];
         s0_dx_ff     <= req_tdata[59:48];
         s0_dy_ff     <= req_tdata[71:60];
      end
   end

   // Numerator of the source position: (2d + 1) * src - fit, or zero when the
   // half-pixel center falls before the first source pixel.
   logic [MW-1:0] prod_x, prod_y, m_x, m_y;
   logic          oob;
   rbfs_pkg::side_type side_in;

   always_comb begin
      prod_x = MW'({s0_dx_ff, 1'b1}) * MW'(fit_stat.src_w);
      prod_y = MW'({s0_dy_ff, 1'b1}) * MW'(fit_stat.src_h);
      m_x    = (prod_x > MW'(fit_stat.fit_w)) ? prod_x - MW'(fit_stat.fit_w) : '0;
      m_y    = (prod_y > MW'(fit_stat.fit_h)) ? prod_y - MW'(fit_stat.fit_h) : '0;
      oob    = ({1'b0, s0_dx_ff} >= fit_stat.fit_w) || ({1'b0, s0_dy_ff} >= fit_stat.fit_h);
      side_in.sample     = (s0_action_ff == rbfs_pkg::ACT_SAMPLE);
      side_in.oob        = oob;
      side_in.load_index = s0_index_ff;
      side_in.pixel      = s0_pixel_ff;
   end

   logic [QW-1:0] q_x, q_y;

   rbfs_pos_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock(clock), .en(en), .fit(fit_stat.fit_w), .m_in(m_x), .q_out(q_x)
   );

   rbfs_pos_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock(clock), .en(en), .fit(fit_stat.fit_h), .m_in(m_y), .q_out(q_y)
   );

   // Item data rides beside the dividers.
   logic               side_vld_ff [0:QW];
   rbfs_pkg::side_type side_ff     [0:QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QW; i++) begin
            side_vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         side_vld_ff[0] <= s0_valid_ff;
         for (int i = 0; i < QW; i++) begin
            side_vld_ff[i+1] <= side_vld_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 0; i < QW; i++) begin
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   // Clamp positions and split them into pixel and fraction.
   logic [QW-1:0]        top_x, top_y, pos_x, pos_y;
   logic [SW-1:0]        x0, y0, x1, y1;
   logic [SW-1:0]        sp_x0_ff, sp_x1_ff, sp_y0_ff, sp_y1_ff;
   logic [FRAC_BITS-1:0] sp_fx_ff, sp_fy_ff;
   logic                 sp_vld_ff;
   rbfs_pkg::side_type   sp_side_ff;

   always_comb begin
      top_x = {fit_stat.src_w - SW'(1), {FRAC_BITS{1'b0}}};
      top_y = {fit_stat.src_h - SW'(1), {FRAC_BITS{1'b0}}};
      pos_x = (q_x > top_x) ? top_x : q_x;
      pos_y = (q_y > top_y) ? top_y : q_y;
      x0    = pos_x[QW-1:FRAC_BITS];
      y0    = pos_y[QW-1:FRAC_BITS];
      x1    = (({1'b0, x0} + (SW+1)'(1)) < {1'b0, fit_stat.src_w}) ? x0 + SW'(1)
                                                                    : fit_stat.src_w - SW'(1);
      y1    = (({1'b0, y0} + (SW+1)'(1)) < {1'b0, fit_stat.src_h}) ? y0 + SW'(1)
                                                                    : fit_stat.src_h - SW'(1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sp_x0_ff   <= x0;
         sp_x1_ff   <= x1;
         sp_y0_ff   <= y0;
         sp_y1_ff   <= y1;
         sp_fx_ff   <= pos_x[FRAC_BITS-1:0];
         sp_fy_ff   <= pos_y[FRAC_BITS-1:0];
         sp_side_ff <= side_ff[QW];
      end
   end

   // Row-major addresses of the four neighbors.
   logic [ROWW-1:0]      row0, row1, sum00, sum01, sum10, sum11;
   logic [AW-1:0]        sa_a00_ff, sa_a01_ff, sa_a10_ff, sa_a11_ff;
   logic [FRAC_BITS-1:0] sa_fx_ff, sa_fy_ff;
   logic                 sa_vld_ff;
   rbfs_pkg::side_type   sa_side_ff;

   always_comb begin
      row0  = ROWW'(sp_y0_ff) * ROWW'(fit_stat.src_w);
      row1  = ROWW'(sp_y1_ff) * ROWW'(fit_stat.src_w);
      sum00 = row0 + ROWW'(sp_x0_ff);
      sum01 = row0 + ROWW'(sp_x1_ff);
      sum10 = row1 + ROWW'(sp_x0_ff);
      sum11 = row1 + ROWW'(sp_x1_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_a00_ff  <= sum00[AW-1:0];
         sa_a01_ff  <= sum01[AW-1:0];
         sa_a10_ff  <= sum10[AW-1:0];
         sa_a11_ff  <= sum11[AW-1:0];
         sa_fx_ff   <= sp_fx_ff;
         sa_fy_ff   <= sp_fy_ff;
         sa_side_ff <= sp_side_ff;
      end
   end

   // Pixel store: loads write both copies here, samples read here.
   logic                 ram_we;
   logic [31:0]          p00, p01, p10, p11;
   logic [FRAC_BITS-1:0] sm_fx_ff, sm_fy_ff;
   logic                 sm_vld_ff;
   rbfs_pkg::side_type   sm_side_ff;

   assign ram_we = sa_vld_ff && !sa_side_ff.sample;

   rbfs_pixel_ram u_ram_top (
      .clock(clock), .en(en), .we(ram_we),
      .waddr(sa_side_ff.load_index), .wdata(sa_side_ff.pixel),
      .raddr0(sa_a00_ff), .raddr1(sa_a01_ff), .rdata0(p00), .rdata1(p01)
   );

   rbfs_pixel_ram u_ram_bot (
      .clock(clock), .en(en), .we(ram_we),
      .waddr(sa_side_ff.load_index), .wdata(sa_side_ff.pixel),
      .raddr0(sa_a10_ff), .raddr1(sa_a11_ff), .rdata0(p10), .rdata1(p11)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sm_fx_ff   <= sa_fx_ff;
         sm_fy_ff   <= sa_fy_ff;
         sm_side_ff <= sa_side_ff;
      end
   end

   // Horizontal blend of each channel.
   logic [TOPW-1:0]    sb1_top_ff [0:3];
   logic [TOPW-1:0]    sb1_bot_ff [0:3];
   logic [TOPW-1:0]    top_c [0:3];
   logic [TOPW-1:0]    bot_c [0:3];
   logic [WTW-1:0]     wx0;
   logic [FRAC_BITS-1:0] sb1_fy_ff;
   logic               sb1_vld_ff;
   rbfs_pkg::side_type sb1_side_ff;

   always_comb begin
      wx0 = ONE - WTW'(sm_fx_ff);
      for (int c = 0; c < 4; c++) begin
         top_c[c] = TOPW'(p00[CW*c +: CW]) * TOPW'(wx0) + TOPW'(p01[CW*c +: CW]) * TOPW'(sm_fx_ff);
         bot_c[c] = TOPW'(p10[CW*c +: CW]) * TOPW'(wx0) + TOPW'(p11[CW*c +: CW]) * TOPW'(sm_fx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 4; c++) begin
            sb1_top_ff[c] <= top_c[c];
            sb1_bot_ff[c] <= bot_c[c];
         end
         sb1_fy_ff   <= sm_fy_ff;
         sb1_side_ff <= sm_side_ff;
      end
   end

   // Vertical weighting.
   logic [PRDW-1:0]    sb2_tt_ff [0:3];
   logic [PRDW-1:0]    sb2_bb_ff [0:3];
   logic [WTW-1:0]     wy0;
   logic               sb2_vld_ff;
   rbfs_pkg::side_type sb2_side_ff;

   assign wy0 = ONE - WTW'(sb1_fy_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 4; c++) begin
            sb2_tt_ff[c] <= PRDW'(sb1_top_ff[c]) * PRDW'(wy0);
            sb2_bb_ff[c] <= PRDW'(sb1_bot_ff[c]) * PRDW'(sb1_fy_ff);
         end
         sb2_side_ff <= sb1_side_ff;
      end
   end

   // Valid flags of the tail stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_vld_ff  <= 1'b0;
         sa_vld_ff  <= 1'b0;
         sm_vld_ff  <= 1'b0;
         sb1_vld_ff <= 1'b0;
         sb2_vld_ff <= 1'b0;
      end else if (en) begin
         sp_vld_ff  <= side_vld_ff[QW];
         sa_vld_ff  <= sp_vld_ff;
         sm_vld_ff  <= sa_vld_ff;
         sb1_vld_ff <= sm_vld_ff;
         sb2_vld_ff <= sb1_vld_ff;
      end
   end

   // Final sum, truncation with saturation and the output register.
   logic [PRDW:0]      sum_c [0:3];
   logic [CW-1:0]      chan_c [0:3];
   logic               rsp_valid_ff;
   logic [CW-1:0]      rsp_ch_ff [0:3];
   logic [FW-1:0]      rsp_fit_w_ff, rsp_fit_h_ff;
   logic               rsp_status_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         sum_c[c]  = (PRDW+1)'(sb2_tt_ff[c]) + (PRDW+1)'(sb2_bb_ff[c]);
         chan_c[c] = (sum_c[c][PRDW:2*FRAC_BITS] > (PRDW+1-2*FRAC_BITS)'(CH_MAX))
                     ? CH_MAX : sum_c[c][2*FRAC_BITS +: CW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sb2_vld_ff && sb2_side_ff.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 4; c++) begin
            rsp_ch_ff[c] <= sb2_side_ff.oob ? '0 : chan_c[c];
         end
         rsp_fit_w_ff  <= fit_stat.fit_w;
         rsp_fit_h_ff  <= fit_stat.fit_h;
         rsp_status_ff <= sb2_side_ff.oob;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {6'd0, rsp_fit_h_ff, rsp_fit_w_ff,
                        rsp_ch_ff[3], rsp_ch_ff[2], rsp_ch_ff[1], rsp_ch_ff[0]};

   // Accepted write to one of the four registers.
   logic csr_known_wr;
   assign csr_known_wr = csr_valid && csr_ready && (csr_index <= rbfs_pkg::REG_LIMIT_HEIGHT);

   // No item enters while a refit runs.
   `ASSERT_IMPLY(a_refit_blocks_req, clock, reset, fit_stat.busy, !req_tready)
   // A known register write always starts a refit.
   `ASSERT_NEXT(a_write_starts_refit, clock, reset, csr_known_wr, fit_stat.busy)
   // A sample outside the fitted frame carries zero channels.
   `ASSERT_IMPLY(a_oob_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[31:0] == 32'd0)
   // The fitted frame is never empty.
   `ASSERT_IMPLY(a_fit_nonzero, clock, reset, rsp_tvalid, rsp_fit_w_ff != '0 && rsp_fit_h_ff != '0)
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the RGBA bilinear fit scaler.
module testbench;
   localparam int FRAC_BITS   = 16;
   localparam int MAX_SRC     = 256;
   localparam int MAX_OUT     = 4096;
   localparam int CSR_IDX_W   = rbfs_pkg::CSR_IDX_W;
   localparam int FIT_W       = rbfs_pkg::FIT_W;
   localparam int SRC_W       = rbfs_pkg::SRC_W;
   localparam int ADDR_W      = rbfs_pkg::ADDR_W;
   localparam int PIX_W       = rbfs_pkg::PIX_W;
   localparam int DEST_W      = rbfs_pkg::DEST_W;
   // Covers the sample pipeline; leave some margin on top.
   localparam int SETTLE      = FRAC_BITS + 32;
   localparam int PHASE_ITEMS = 110;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_FIRST = rbfs_pkg::REG_LIMIT_HEIGHT + 8'd1;

   typedef struct packed {
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [7:0]       alpha;
      logic [FIT_W-1:0] fit_w;
      logic [FIT_W-1:0] fit_h;
      logic             status;
   } pixel_result_type;

   typedef struct packed {
      logic              action;
      logic [ADDR_W-1:0] index;
      logic [PIX_W-1:0]  pixel;
      logic [DEST_W-1:0] dx;
      logic [DEST_W-1:0] dy;
      logic              typed;
      pixel_result_type  result;
   } stim_row_type;

   // Four neighbor addresses and the fractions of one sample position.
   typedef struct {
      logic [ADDR_W-1:0] addr [4];
      longint unsigned   fx;
      longint unsigned   fy;
   } taps_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [71:0]          req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [63:0]          rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [FIT_W-1:0]     csr_data   = '0;

   rgba_bilinear_fit_scaler dut (.*);

   // Shadow of the block state.
   logic [PIX_W-1:0] raster [65536];
   bit               raster_written [65536];
   int unsigned      src_w_reg, src_h_reg, lim_w_reg, lim_h_reg;
   int unsigned      fit_w_reg, fit_h_reg;

   pixel_result_type pending_pixels [$];
   int               gap_pct, stall_pct;
   int               fail_count, load_count, sample_count, miss_count, result_count;
   int               item_count;

   // Directed rows; the registers are all 1 here, so the raster is one pixel.
   stim_row_type directed_rows [12] = '{
      '{rbfs_pkg::ACT_LOAD,   16'h0000, 32'hffffffff, 12'd0,    12'd0,    1'b0, '0},
      '{rbfs_pkg::ACT_SAMPLE, 16'hffff, 32'hffffffff, 12'd0,    12'd0,    1'b1,
         '{8'hff, 8'hff, 8'hff, 8'hff, 13'd1, 13'd1, 1'b0}},
      '{rbfs_pkg::ACT_SAMPLE, 16'h0000, 32'h00000000, 12'd4095, 12'd4095, 1'b1,
         '{8'h00, 8'h00, 8'h00, 8'h00, 13'd1, 13'd1, 1'b1}},
      '{rbfs_pkg::ACT_SAMPLE, 16'h0000, 32'h00000000, 12'd1,    12'd0,    1'b1,
         '{8'h00, 8'h00, 8'h00, 8'h00, 13'd1, 13'd1, 1'b1}},
      '{rbfs_pkg::ACT_SAMPLE, 16'h0000, 32'h00000000, 12'd0,    12'd1,    1'b1,
         '{8'h00, 8'h00, 8'h00, 8'h00, 13'd1, 13'd1, 1'b1}},
      '{rbfs_pkg::ACT_LOAD,   16'hffff, 32'hffffffff, 12'd4095, 12'd4095, 1'b0, '0},
      '{rbfs_pkg::ACT_LOAD,   16'h0000, 32'h00000000, 12'd0,    12'd0,    1'b0, '0},
      '{rbfs_pkg::ACT_SAMPLE, 16'h0000, 32'h00000000, 12'd0,    12'd0,    1'b1,
         '{8'h00, 8'h00, 8'h00, 8'h00, 13'd1, 13'd1, 1'b0}},
      '{rbfs_pkg::ACT_LOAD,   16'h0000, 32'h80ff0001, 12'd0,    12'd0,    1'b0, '0},
      '{rbfs_pkg::ACT_SAMPLE, 16'h5a5a, 32'ha5a5a5a5, 12'd0,    12'd0,    1'b0, '0},
      '{rbfs_pkg::ACT_LOAD,   16'hffff, 32'h00000000, 12'd0,    12'd0,    1'b0, '0},
      '{rbfs_pkg::ACT_SAMPLE, 16'h0000, 32'h00000000, 12'd4095, 12'd0,    1'b0, '0}
   };

   // Fixed register settings, as source width, source height, limit width, limit
   // height; several are out of range on purpose to exercise saturation.
   int unsigned fixed_settings [8][4] = '{
      '{256, 256, 4096, 4096}, '{1, 1, 1, 1}, '{256, 1, 4096, 4096},
      '{1, 256, 4096, 4096}, '{0, 511, 8191, 0}, '{7, 5, 3, 2},
      '{13, 9, 13, 9}, '{256, 256, 256, 256}
   };

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Fit the source into the limit frame, aspect kept, rounded to nearest.
   function automatic void refit_frame();
      longint unsigned w, h, lw, lh, fw, fh;
      w  = clamp_to(src_w_reg, MAX_SRC);
      h  = clamp_to(src_h_reg, MAX_SRC);
      lw = clamp_to(lim_w_reg, MAX_OUT);
      lh = clamp_to(lim_h_reg, MAX_OUT);
      if (lw * h <= lh * w) begin
         fw = lw;
         fh = (2 * h * lw + w) / (2 * w);
      end else begin
         fh = lh;
         fw = (2 * w * lh + h) / (2 * h);
      end
      fit_w_reg = 32'((fw < 1) ? 1 : fw);
      fit_h_reg = 32'((fh < 1) ? 1 : fh);
   endfunction

   // Half-pixel-centered source position with FRAC_BITS fraction bits, clamped.
   function automatic longint unsigned source_position(longint unsigned d,
                                                       longint unsigned src,
                                                       longint unsigned fit);
      longint unsigned a, b, p, top;
      a = ((2 * d + 1) * src) << FRAC_BITS;
      b = fit << FRAC_BITS;
      if (a <= b) return 0;
      p   = (a - b) / (2 * fit);
      top = (src - 1) << FRAC_BITS;
      return (p > top) ? top : p;
   endfunction

   function automatic taps_type neighbor_taps(int unsigned dx, int unsigned dy);
      taps_type        t;
      longint unsigned w, h, px, py, x0, y0, x1, y1;
      w  = clamp_to(src_w_reg, MAX_SRC);
      h  = clamp_to(src_h_reg, MAX_SRC);
      px = source_position(dx, w, fit_w_reg);
      py = source_position(dy, h, fit_h_reg);
      x0 = px >> FRAC_BITS;
      y0 = py >> FRAC_BITS;
      x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
      y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
      t.fx = px & ((64'd1 << FRAC_BITS) - 1);
      t.fy = py & ((64'd1 << FRAC_BITS) - 1);
      t.addr[0] = ADDR_W'(y0 * w + x0);
      t.addr[1] = ADDR_W'(y0 * w + x1);
      t.addr[2] = ADDR_W'(y1 * w + x0);
      t.addr[3] = ADDR_W'(y1 * w + x1);
      return t;
   endfunction

   function automatic pixel_result_type bilinear_pixel(int unsigned dx, int unsigned dy);
      pixel_result_type r;
      taps_type         t;
      longint unsigned  one, top, bot, v;
      logic [7:0]       ch [4];
      logic [PIX_W-1:0] p [4];
      one     = 64'd1 << FRAC_BITS;
      r       = '0;
      r.fit_w = FIT_W'(fit_w_reg);
      r.fit_h = FIT_W'(fit_h_reg);
      if (dx >= fit_w_reg || dy >= fit_h_reg) begin
         r.status = 1'b1;
         return r;
      end
      t = neighbor_taps(dx, dy);
      for (int i = 0; i < 4; i++) p[i] = raster[t.addr[i]];
      for (int c = 0; c < 4; c++) begin
         top = p[0][8*c +: 8] * (one - t.fx) + p[1][8*c +: 8] * t.fx;
         bot = p[2][8*c +: 8] * (one - t.fx) + p[3][8*c +: 8] * t.fx;
         v   = (top * (one - t.fy) + bot * t.fy) >> (2 * FRAC_BITS);
         ch[c] = (v > 255) ? 8'hff : v[7:0];
      end
      r.red   = ch[0];
      r.green = ch[1];
      r.blue  = ch[2];
      r.alpha = ch[3];
      return r;
   endfunction

   // Offers one item and updates the shadow state once it is taken.
   task automatic send_item(logic action, logic [ADDR_W-1:0] index,
                            logic [PIX_W-1:0] pixel, logic [DEST_W-1:0] dx,
                            logic [DEST_W-1:0] dy, logic typed, pixel_result_type known);
      pixel_result_type want;
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {dy, dx, pixel, index};
      do @(posedge clock); while (!req_tready);
      item_count++;
      if (action == rbfs_pkg::ACT_LOAD) begin
         raster[index]         = pixel;
         raster_written[index] = 1'b1;
         load_count++;
      end else begin
         want = typed ? known : bilinear_pixel(dx, dy);
         pending_pixels = {pending_pixels, want};
         sample_count++;
         if (dx >= fit_w_reg || dy >= fit_h_reg) miss_count++;
      end
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [FIT_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         rbfs_pkg::REG_SOURCE_WIDTH:  src_w_reg = value[SRC_W-1:0];
         rbfs_pkg::REG_SOURCE_HEIGHT: src_h_reg = value[SRC_W-1:0];
         rbfs_pkg::REG_LIMIT_WIDTH:   lim_w_reg = value;
         rbfs_pkg::REG_LIMIT_HEIGHT:  lim_h_reg = value;
         default: ;
      endcase
      if (index <= rbfs_pkg::REG_LIMIT_HEIGHT) refit_frame();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Lets every expected result arrive, then the tail of the pipeline empty.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            $error("result item arrived with nothing expected");
            fail_count++;
         end else begin
            pixel_result_type e;
            e = pending_pixels.pop_front();
            result_count++;
            check_field("out_red",       e.red,    rsp_tdata[7:0]);
            check_field("out_green",     e.green,  rsp_tdata[15:8]);
            check_field("out_blue",      e.blue,   rsp_tdata[23:16]);
            check_field("out_alpha",     e.alpha,  rsp_tdata[31:24]);
            check_field("fitted_width",  e.fit_w,  rsp_tdata[44:32]);
            check_field("fitted_height", e.fit_h,  rsp_tdata[57:45]);
            check_field("status",        e.status, rsp_tuser);
         end
      end
   end

   initial begin
      int unsigned   setting [4];
      int unsigned   dx, dy;
      taps_type      t;
      int            phase_count;
      int            phase_end;
      reset = 1'b1;
      src_w_reg = 1; src_h_reg = 1; lim_w_reg = 1; lim_h_reg = 1;
      fit_w_reg = 1; fit_h_reg = 1;
      gap_pct = 0;
      stall_pct = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows with the reset configuration.
      foreach (directed_rows[i])
         send_item(directed_rows[i].action, directed_rows[i].index,
                   directed_rows[i].pixel, directed_rows[i].dx, directed_rows[i].dy,
                   directed_rows[i].typed, directed_rows[i].result);
      wait_idle();

      phase_count = 14;
      for (int ph = 0; ph < phase_count; ph++) begin
         if (ph < 8) begin
            setting = fixed_settings[ph];
         end else begin
            setting[0] = $urandom_range(1, MAX_SRC);
            setting[1] = $urandom_range(1, MAX_SRC);
            setting[2] = ($urandom_range(1)) ? $urandom_range(1, 64)
                                             : $urandom_range(8191);
            setting[3] = ($urandom_range(1)) ? $urandom_range(1, 64)
                                             : $urandom_range(8191);
         end
         // Rotate the idling pattern from phase to phase.
         case (ph % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 52; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 52; end
            default: begin gap_pct = 33; stall_pct = 33; end
         endcase
         write_register(rbfs_pkg::REG_SOURCE_WIDTH,  FIT_W'(setting[0]));
         write_register(rbfs_pkg::REG_SOURCE_HEIGHT, FIT_W'(setting[1]));
         write_register(rbfs_pkg::REG_LIMIT_WIDTH,   FIT_W'(setting[2]));
         write_register(rbfs_pkg::REG_LIMIT_HEIGHT,  FIT_W'(setting[3]));
         // A write to an index outside the register file must change nothing.
         write_register(CSR_IDX_W'(REG_UNUSED_FIRST + $urandom_range(251)),
                        FIT_W'($urandom_range(8191)));

         // Each phase sends at least PHASE_ITEMS items, the pixel fills included.
         phase_end = item_count + PHASE_ITEMS;
         while (item_count < phase_end) begin
            if ($urandom_range(99) < 22) begin
               // Stray load anywhere in the store.
               send_item(rbfs_pkg::ACT_LOAD, ADDR_W'($urandom), PIX_W'($urandom),
                         DEST_W'($urandom), DEST_W'($urandom), 1'b0, '0);
            end else begin
               if ($urandom_range(99) < 12) begin
                  dx = $urandom_range(4095);
                  dy = $urandom_range(4095);
               end else begin
                  dx = $urandom_range(fit_w_reg - 1);
                  dy = $urandom_range(fit_h_reg - 1);
               end
               // Fill any neighbor pixel that was never loaded before reading it.
               if (dx < fit_w_reg && dy < fit_h_reg) begin
                  t = neighbor_taps(dx, dy);
                  for (int k = 0; k < 4; k++)
                     if (!raster_written[t.addr[k]])
                        send_item(rbfs_pkg::ACT_LOAD, t.addr[k], PIX_W'($urandom),
                                  DEST_W'($urandom), DEST_W'($urandom), 1'b0, '0);
               end
               send_item(rbfs_pkg::ACT_SAMPLE, ADDR_W'($urandom), PIX_W'($urandom),
                         DEST_W'(dx), DEST_W'(dy), 1'b0, '0);
            end
         end
         wait_idle();
      end

      $display("Covered %0d register settings: %0d loads and %0d samples, %0d of them",
               phase_count, load_count, sample_count, miss_count);
      $display("outside the fitted frame; %0d result items checked.", result_count);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

// ===== rgba_bilinear_fit_scaler.f =====
+incdir+design
design/rbfs_pkg.sv
design/rbfs_fit_unit.sv
design/rbfs_pos_div.sv
design/rbfs_pixel_ram.sv
design/rgba_bilinear_fit_scaler.sv
verif/testbench.sv
